// ===== rtl/core/rf_remote_code_decoder_assert.svh =====
// Assertion macros for the remote code decoder.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RF_REMOTE_CODE_DECODER_ASSERT_SVH
`define RF_REMOTE_CODE_DECODER_ASSERT_SVH

// same-cycle implication
`define RFCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RFCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rfcd_pkg.sv =====
// Package of the remote code decoder: word types, constants, register indexes.
// No dependencies.
package rfcd_pkg;

  localparam int unsigned DEF_CODE_BITS  = 24;
  localparam int unsigned DEF_TIMER_BITS = 24;

  localparam int unsigned TICKS_W = 16;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned CLOCK_W = 8;
  localparam int unsigned SYNC_W  = 16;
  localparam int unsigned WIN_W   = 12;

  localparam int unsigned SYNC_SCALE = 124;
  // t / 124 == (t * 33826) >> 22 for every t below 255 * 124
  localparam int unsigned DIV_MULT   = 33826;
  localparam int unsigned DIV_SHIFT  = 22;
  localparam int unsigned DIV_IN_W   = 15;
  localparam int unsigned DIV_PROD_W = 32;

  localparam int unsigned ONE_LO  = 2;
  localparam int unsigned ONE_HI  = 6;
  localparam int unsigned ZERO_LO = 10;
  localparam int unsigned ZERO_HI = 14;

  localparam logic [CFG_W-1:0] MIN_SYNC_RST = 8'd32;
  localparam logic [CFG_W-1:0] MAX_SYNC_RST = 8'd128;

  typedef enum logic {
    REG_MIN_SYNC = 1'b0,
    REG_MAX_SYNC = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TICKS_W-1:0] elapsed_ticks;
    logic               line_level;
    logic               clear_code;
  } rfcd_item_t;

  typedef struct packed {
    logic               code_valid;
    logic [VALUE_W-1:0] code_value;
    logic [CLOCK_W-1:0] code_clock;
    logic               code_new;
  } rfcd_result_t;

endpackage

// ===== rtl/core/rfcd_ifs.sv =====
// Valid/ready channel interfaces for the input word and the result word.
// Depends on rfcd_pkg.
interface rfcd_in_if import rfcd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [TICKS_W-1:0] elapsed_ticks;
  logic               line_level;
  logic               clear_code;

  modport source (output valid, elapsed_ticks, line_level, clear_code, input ready);
  modport sink   (input valid, elapsed_ticks, line_level, clear_code, output ready);
endinterface

interface rfcd_out_if import rfcd_pkg::*;;
  logic               valid;
  logic               ready;
  logic               code_valid;
  logic [VALUE_W-1:0] code_value;
  logic [CLOCK_W-1:0] code_clock;
  logic               code_new;

  modport source (output valid, code_valid, code_value, code_clock, code_new, input ready);
  modport sink   (input valid, code_valid, code_value, code_clock, code_new, output ready);
endinterface

// ===== rtl/core/rfcd_core.sv =====
// Decoder state and per-word decode: pulse timer, sync and bit windows, code latch.
// Depends on rfcd_pkg.
module rfcd_core import rfcd_pkg::*; #(
  parameter int unsigned CODE_BITS  = DEF_CODE_BITS,
  parameter int unsigned TIMER_BITS = DEF_TIMER_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  rfcd_item_t       item,
  input  logic [CFG_W-1:0] min_sync,
  input  logic [CFG_W-1:0] max_sync,
  output rfcd_result_t     result
);

  localparam int unsigned POS_W = $clog2(CODE_BITS + 1);
  localparam int unsigned IDX_W = $clog2(CODE_BITS);
  localparam logic [POS_W-1:0] POS_IDLE = POS_W'(CODE_BITS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(CODE_BITS - 1);

  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic                  last_r, last_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CODE_BITS-1:0]  shift_r, shift_nxt;
  logic [CLOCK_W-1:0]    unit_r, unit_nxt;
  logic                  lat_vld_r, lat_vld_nxt;
  logic [CODE_BITS-1:0]  lat_code_r, lat_code_nxt;
  logic [CLOCK_W-1:0]    lat_clk_r, lat_clk_nxt;
  logic                  fresh;

  logic [TIMER_BITS:0]   sum;
  logic [TIMER_BITS-1:0] t;
  logic [SYNC_W-1:0]     sync_lo, sync_hi;
  logic                  in_sync, is_one, is_zero, rise;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [CLOCK_W-1:0]    clk_meas;
  logic [WIN_W-1:0]      one_lo, one_hi, zero_lo, zero_hi;
  logic [IDX_W-1:0]      bit_idx;

  assign sum = {1'b0, timer_r} + (TIMER_BITS + 1)'(item.elapsed_ticks);
  assign t   = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];

  assign sync_lo = SYNC_W'(min_sync) * SYNC_W'(SYNC_SCALE);
  assign sync_hi = SYNC_W'(max_sync) * SYNC_W'(SYNC_SCALE);
  assign in_sync = (t > TIMER_BITS'(sync_lo)) && (t < TIMER_BITS'(sync_hi));

  assign div_prod = DIV_PROD_W'(t[DIV_IN_W-1:0]) * DIV_PROD_W'(DIV_MULT);
  assign clk_meas = div_prod[DIV_SHIFT +: CLOCK_W];

  assign one_lo  = WIN_W'(unit_r) * WIN_W'(ONE_LO);
  assign one_hi  = WIN_W'(unit_r) * WIN_W'(ONE_HI);
  assign zero_lo = WIN_W'(unit_r) * WIN_W'(ZERO_LO);
  assign zero_hi = WIN_W'(unit_r) * WIN_W'(ZERO_HI);
  assign is_one  = (t > TIMER_BITS'(one_lo)) && (t < TIMER_BITS'(one_hi));
  assign is_zero = (t > TIMER_BITS'(zero_lo)) && (t < TIMER_BITS'(zero_hi));

  assign rise    = item.line_level && !last_r;
  assign bit_idx = pos_r[IDX_W-1:0];

  always_comb begin
    timer_nxt    = (item.line_level != last_r) ? '0 : t;
    last_nxt     = item.line_level;
    pos_nxt      = pos_r;
    shift_nxt    = shift_r;
    unit_nxt     = unit_r;
    lat_vld_nxt  = lat_vld_r && !item.clear_code;
    lat_code_nxt = item.clear_code ? '0 : lat_code_r;
    lat_clk_nxt  = item.clear_code ? '0 : lat_clk_r;
    fresh        = 1'b0;
    if (rise) begin
      if (in_sync) begin
        unit_nxt = clk_meas;
        pos_nxt  = POS_LAST;
      end else if (pos_r >= POS_IDLE) begin
        // noise outside a frame
        lat_vld_nxt  = 1'b0;
        lat_code_nxt = '0;
        lat_clk_nxt  = '0;
      end else if (is_one || is_zero) begin
        shift_nxt[bit_idx] = is_one;
        if (pos_r == '0) begin
          pos_nxt = POS_IDLE;
          if (!lat_vld_nxt) begin
            lat_vld_nxt  = 1'b1;
            lat_code_nxt = shift_nxt;
            lat_clk_nxt  = unit_r;
            fresh        = 1'b1;
          end
        end else begin
          pos_nxt = pos_r - 1'b1;
        end
      end else begin
        pos_nxt = POS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r    <= '0;
      last_r     <= 1'b0;
      pos_r      <= POS_IDLE;
      shift_r    <= '0;
      unit_r     <= '0;
      lat_vld_r  <= 1'b0;
      lat_code_r <= '0;
      lat_clk_r  <= '0;
    end else if (step) begin
      timer_r    <= timer_nxt;
      last_r     <= last_nxt;
      pos_r      <= pos_nxt;
      shift_r    <= shift_nxt;
      unit_r     <= unit_nxt;
      lat_vld_r  <= lat_vld_nxt;
      lat_code_r <= lat_code_nxt;
      lat_clk_r  <= lat_clk_nxt;
    end
  end

  assign result.code_valid = lat_vld_nxt;
  assign result.code_value = VALUE_W'(lat_code_nxt);
  assign result.code_clock = lat_clk_nxt;
  assign result.code_new   = fresh;

endmodule

// ===== rtl/core/rf_remote_code_decoder.sv =====
// Remote code decoder top level: input word register, decode, result word register.
// Words pass input register then result register; one word per cycle while out_chan.ready.
// Input and result registers keep flowing under a stalled result channel until both fill.
// Reset (rst_n, synchronous, active low): decoder idle, latch empty, bounds 32 and 128.
// Depends on rfcd_pkg, rfcd_ifs, rfcd_core and rf_remote_code_decoder_assert.svh.
`include "rf_remote_code_decoder_assert.svh"
module rf_remote_code_decoder import rfcd_pkg::*; #(
  parameter int unsigned CODE_BITS  = DEF_CODE_BITS,
  parameter int unsigned TIMER_BITS = DEF_TIMER_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  rfcd_in_if.sink          in_chan,
  rfcd_out_if.source       out_chan,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] min_sync_r, max_sync_r;
  logic             s1_vld_r, s1_vld_nxt;
  rfcd_item_t       s1_item_r;
  logic             out_vld_r, out_vld_nxt;
  rfcd_result_t     out_res_r;
  rfcd_result_t     core_res;
  logic             out_adv, step, in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sync_r <= MIN_SYNC_RST;
      max_sync_r <= MAX_SYNC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_SYNC: min_sync_r <= cfg_data;
        REG_MAX_SYNC: max_sync_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_adv       = !out_vld_r || out_chan.ready;
  assign step          = s1_vld_r && out_adv;
  assign in_chan.ready = !s1_vld_r || out_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_vld_nxt = in_acc ? 1'b1 : (step ? 1'b0 : s1_vld_r);
    out_vld_nxt = step ? 1'b1 : (out_chan.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.elapsed_ticks <= in_chan.elapsed_ticks;
      s1_item_r.line_level    <= in_chan.line_level;
      s1_item_r.clear_code    <= in_chan.clear_code;
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  rfcd_core #(
    .CODE_BITS  (CODE_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (s1_item_r),
    .min_sync (min_sync_r),
    .max_sync (max_sync_r),
    .result   (core_res)
  );

  assign out_chan.valid      = out_vld_r;
  assign out_chan.code_valid = out_res_r.code_valid;
  assign out_chan.code_value = out_res_r.code_value;
  assign out_chan.code_clock = out_res_r.code_clock;
  assign out_chan.code_new   = out_res_r.code_new;

  `RFCD_ASSERT_NOW(a_new_is_valid, out_vld_r && out_res_r.code_new, out_res_r.code_valid, "new code without valid latch")
  `RFCD_ASSERT_NOW(a_empty_is_zero, out_vld_r && !out_res_r.code_valid, (out_res_r.code_value == '0) && (out_res_r.code_clock == '0), "empty latch shows data")
  `RFCD_ASSERT_NOW(a_stall_only_full, !in_chan.ready, s1_vld_r && out_vld_r && !out_chan.ready, "input stalled with room")
  `RFCD_ASSERT_NEXT(a_fresh_reaches_out, step && core_res.code_new, out_vld_r && out_res_r.code_new, "latched code lost")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for rf_remote_code_decoder: drives pulse-width words, predicts each
// result word in a scoreboard class and compares every field at the result port.
// Depends on rfcd_pkg, rfcd_ifs and the decoder RTL.
module tb import rfcd_pkg::*;;

  localparam int unsigned FRAME_BITS = DEF_CODE_BITS;
  localparam int unsigned BIT_W      = $clog2(FRAME_BITS + 1);
  localparam int unsigned WATCHDOG   = 1000;

  class code_tracker;
    logic [CFG_W-1:0]          sync_lo;
    logic [CFG_W-1:0]          sync_hi;
    logic [DEF_TIMER_BITS-1:0] run_ticks;
    logic                      level_q;
    logic [BIT_W-1:0]          bit_idx;
    logic [FRAME_BITS-1:0]     assembled;
    logic [CLOCK_W-1:0]        sync_unit;
    rfcd_result_t              held;
    rfcd_result_t              due[$];
    int                        errors;

    function new();
      sync_lo   = MIN_SYNC_RST;
      sync_hi   = MAX_SYNC_RST;
      run_ticks = '0;
      level_q   = 1'b0;
      bit_idx   = BIT_W'(FRAME_BITS);
      assembled = '0;
      sync_unit = '0;
      held      = '0;
      errors    = 0;
    endfunction

    function void set_bound(cfg_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_MIN_SYNC: sync_lo = v;
        REG_MAX_SYNC: sync_hi = v;
      endcase
    endfunction

    // rising edge: classify the low time just measured
    function bit classify_low(int unsigned t);
      int unsigned c;
      c = 32'(sync_unit);
      if (t > sync_lo * SYNC_SCALE && t < sync_hi * SYNC_SCALE) begin
        sync_unit = CLOCK_W'(t / SYNC_SCALE);
        bit_idx   = BIT_W'(FRAME_BITS - 1);
        return 1'b0;
      end
      if (bit_idx >= FRAME_BITS) begin
        held = '0;
        return 1'b0;
      end
      if (t > c * ONE_LO && t < c * ONE_HI) begin
        assembled[bit_idx] = 1'b1;
      end else if (t > c * ZERO_LO && t < c * ZERO_HI) begin
        assembled[bit_idx] = 1'b0;
      end else begin
        bit_idx = BIT_W'(FRAME_BITS);
        return 1'b0;
      end
      if (bit_idx == 0) begin
        bit_idx = BIT_W'(FRAME_BITS);
        if (!held.code_valid) begin
          held.code_valid = 1'b1;
          held.code_value = VALUE_W'(assembled);
          held.code_clock = sync_unit;
          return 1'b1;
        end
        return 1'b0;
      end
      bit_idx--;
      return 1'b0;
    endfunction

    function void note_word(rfcd_item_t w);
      logic [DEF_TIMER_BITS:0] sum;
      rfcd_result_t            r;
      logic                    fresh;
      fresh = 1'b0;
      if (w.clear_code) held = '0;
      sum       = {1'b0, run_ticks} + (DEF_TIMER_BITS + 1)'(w.elapsed_ticks);
      run_ticks = sum[DEF_TIMER_BITS] ? '1 : sum[DEF_TIMER_BITS-1:0];
      if (w.line_level != level_q) begin
        if (!level_q) fresh = classify_low(32'(run_ticks));
        run_ticks = '0;
        level_q   = w.line_level;
      end
      r          = held;
      r.code_new = fresh;
      due.push_back(r);
    endfunction

    function void check_code(rfcd_result_t got);
      rfcd_result_t exp;
      if (due.size() == 0) begin
        $display("%0t: result word with nothing expected: valid=%0b code=%06h clk=%0d new=%0b",
                 $time, got.code_valid, got.code_value, got.code_clock, got.code_new);
        errors++;
        return;
      end
      exp = due.pop_front();
      if (got.code_valid !== exp.code_valid || got.code_value !== exp.code_value ||
          got.code_clock !== exp.code_clock || got.code_new !== exp.code_new) begin
        $display("%0t: mismatch exp valid=%0b code=%06h clk=%0d new=%0b", $time,
                 exp.code_valid, exp.code_value, exp.code_clock, exp.code_new);
        $display("%0t:          got valid=%0b code=%06h clk=%0d new=%0b", $time,
                 got.code_valid, got.code_value, got.code_clock, got.code_new);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             line_now = 1'b0;
  bit               steady = 1'b0;
  int               items_sent = 0;
  int               quiet = 0;
  code_tracker      board = new();

  rfcd_in_if  in_ch();
  rfcd_out_if out_ch();

  rf_remote_code_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_code({out_ch.code_valid, out_ch.code_value, out_ch.code_clock,
                        out_ch.code_new});
    out_ch.ready <= steady || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("%0t: watchdog, no handshake in %0d cycles", $time, WATCHDOG);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit roll_clear();
    return $urandom_range(99) < 8;
  endfunction

  task automatic send_word(input int unsigned ticks, input logic lvl, input logic clr);
    rfcd_item_t w;
    w.elapsed_ticks = TICKS_W'(ticks);
    w.line_level    = lvl;
    w.clear_code    = clr;
    while (!steady && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.elapsed_ticks <= w.elapsed_ticks;
    in_ch.line_level    <= lvl;
    in_ch.clear_code    <= clr;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(w);
    line_now = lvl;
    items_sent++;
  endtask

  // high time, then a low time of low_t ticks ending on a rising edge
  task automatic emit_pulse(input int unsigned low_t);
    int unsigned part;
    send_word(line_now ? $urandom_range(0, 3000) : 0, 1'b0, roll_clear());
    if ($urandom_range(99) < 20) begin
      part = $urandom_range(0, low_t);
      send_word(part, 1'b0, roll_clear());
      low_t -= part;
    end
    send_word(low_t, 1'b1, roll_clear());
  endtask

  task automatic send_frame();
    int unsigned sync_t, c, w;
    if (board.sync_hi <= board.sync_lo) begin
      emit_pulse($urandom_range(0, 40000));
      return;
    end
    sync_t = $urandom_range(board.sync_lo * SYNC_SCALE + 1, board.sync_hi * SYNC_SCALE - 1);
    c = sync_t / SYNC_SCALE;
    emit_pulse(sync_t);
    for (int i = 0; i < FRAME_BITS; i++) begin
      if ($urandom_range(99) < 3) begin
        case ($urandom_range(5))
          0: w = c * ONE_LO;
          1: w = c * ONE_HI;
          2: w = c * ZERO_LO;
          3: w = c * ZERO_HI;
          4: w = $urandom_range(0, c * 8);
          default: w = $urandom_range(0, c * 20);
        endcase
      end else if ($urandom_range(1)) begin
        w = $urandom_range(c * ONE_LO + 1, c * ONE_HI - 1);
      end else begin
        w = $urandom_range(c * ZERO_LO + 1, c * ZERO_HI - 1);
      end
      emit_pulse(w);
    end
  endtask

  task automatic random_traffic(input int n);
    int start;
    int k;
    start = items_sent;
    while (items_sent - start < n) begin
      k = $urandom_range(99);
      if (k < 70)
        send_frame();
      else if (k < 85)
        emit_pulse($urandom_range(0, 40000));
      else
        send_word($urandom_range(0, 65535), 1'($urandom_range(1)), roll_clear());
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bounds(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_SYNC;
    cfg_data  <= lo;
    @(posedge clk);
    board.set_bound(REG_MIN_SYNC, lo);
    cfg_index <= REG_MAX_SYNC;
    cfg_data  <= hi;
    @(posedge clk);
    board.set_bound(REG_MAX_SYNC, hi);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned lo, w;
    in_ch.valid         <= 1'b0;
    in_ch.elapsed_ticks <= '0;
    in_ch.line_level    <= 1'b0;
    in_ch.clear_code    <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_MIN_SYNC;
    cfg_data            <= '0;
    rst_n               <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: window bounds at default 32/128, bit window edges
    write_bounds(8'd32, 8'd128);
    send_word(0, 1'b0, 1'b0);
    send_word(65535, 1'b0, 1'b1);
    send_word(32768, 1'b1, 1'b0);
    emit_pulse(3968);
    emit_pulse(3969);
    emit_pulse(64);
    emit_pulse(15871);
    emit_pulse(255);
    emit_pulse(761);
    emit_pulse(1271);
    emit_pulse(1777);
    emit_pulse(1778);
    emit_pulse(15872);
    send_word(100, 1'b1, 1'b1);
    settle();

    // widest window; timer saturation would wrap into it otherwise
    write_bounds(8'd1, 8'd255);
    w = $urandom_range(125, 31619);
    send_word(line_now ? 100 : 0, 1'b0, 1'b0);
    repeat (256) send_word(65535, 1'b0, 1'b0);
    send_word(256 + w, 1'b1, 1'b0);
    random_traffic(20);
    settle();

    write_bounds(8'd1, 8'd2);
    random_traffic(10);
    settle();

    write_bounds(8'd254, 8'd255);
    random_traffic(20);
    settle();

    // crossed bounds: no sync possible
    write_bounds(8'd255, 8'd1);
    random_traffic(10);
    settle();

    steady = 1'b1;
    lo = $urandom_range(16, 64);
    write_bounds(CFG_W'(lo), CFG_W'(lo + $urandom_range(8, 64)));
    random_traffic(30);
    settle();
    steady = 1'b0;

    lo = $urandom_range(16, 64);
    write_bounds(CFG_W'(lo), CFG_W'(lo + $urandom_range(8, 64)));
    random_traffic(20);
    settle();

    if (board.errors == 0 && board.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
